FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Constants and the month-length table for the epoch-to-calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] EPOCH_SHIFT = 32'd946684800;

  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY  = 6'd24;
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  // Reciprocals: x / 60 = (x * RECIP_DIV60) >> 37, exact for any 32-bit x;
  // x / 24 = (x * RECIP_DIV24) >> 32, exact for x below 2^29
  localparam logic [31:0] RECIP_DIV60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_DIV24 = 32'h0AAA_AAAB;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Days in month m (1..12); February gets one more in a leap year
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/epoch_seconds_to_calendar.sv
// One request at a time: busy from accept until the done cycle ends.
// Second, minute and hour come from three reciprocal multiplies, then the
// year and month loops share one subtractor. Synchronous active-high rst
// returns the sequencer to idle; no result stall.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit Unix timestamp into year offset from 2000, month, day,
// hour, minute and second with a small sequencer around one subtractor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] unix_seconds,
  output logic        busy,
  output logic        done,
  output logic [7:0]  year_offset,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_YEAR  = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Division phases
  localparam logic [1:0] PH_SEC  = 2'd0;
  localparam logic [1:0] PH_MIN  = 2'd1;
  localparam logic [1:0] PH_HOUR = 2'd2;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic        step;
  logic [31:0] quo;
  logic [31:0] qt;
  logic [15:0] days;

  logic [31:0] recip;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [5:0]  qd_low;
  logic [5:0]  rem_now;
  logic        leap;
  logic [4:0]  mlen;
  logic [8:0]  ylen;
  logic [16:0] sub_a;
  logic [16:0] sub_b;
  logic [16:0] diff;
  logic        fits;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  // Leap rule: every fourth year offset
  assign leap  = (year_offset[1:0] == 2'b00);
  assign ylen  = esc_pkg::DAYS_PER_YEAR + {8'd0, leap};
  assign mlen  = esc_pkg::month_days(month, leap);

  // Quotient by reciprocal multiply: by 24 in the hour phase, else by 60
  assign recip = (phase == PH_HOUR) ? esc_pkg::RECIP_DIV24 : esc_pkg::RECIP_DIV60;
  assign prod  = {32'd0, quo} * {32'd0, recip};
  assign quot  = (phase == PH_HOUR) ? prod[63:32] : {5'd0, prod[63:37]};

  // Remainder below 64, so only the low six bits of quotient * divisor matter
  assign qd_low  = (phase == PH_HOUR) ? ({qt[1:0], 4'd0} + {qt[2:0], 3'd0})
                                      : (6'd0 - {qt[3:0], 2'd0});
  assign rem_now = quo[5:0] - qd_low;

  // Shared subtractor operand select
  always_comb begin
    case (state)
      ST_YEAR: begin
        sub_a = {1'b0, days};
        sub_b = {8'd0, ylen};
      end
      ST_MONTH: begin
        sub_a = {1'b0, days};
        sub_b = {12'd0, mlen};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff = sub_a - sub_b;
  assign fits = ~diff[16];

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SEC;
      step  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            quo   <= unix_seconds - esc_pkg::EPOCH_SHIFT;
            step  <= 1'b0;
            phase <= PH_SEC;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!step) begin
            qt   <= quot;
            step <= 1'b1;
          end else begin
            // Quotient becomes the next dividend
            quo  <= qt;
            step <= 1'b0;
            case (phase)
              PH_SEC: begin
                second <= rem_now;
                phase  <= PH_MIN;
              end
              PH_MIN: begin
                minute <= rem_now;
                phase  <= PH_HOUR;
              end
              default: begin
                hour        <= rem_now[4:0];
                days        <= qt[15:0];
                year_offset <= '0;
                phase       <= PH_SEC;
                state       <= ST_YEAR;
              end
            endcase
          end
        end
        ST_YEAR: begin
          if (fits) begin
            days        <= diff[15:0];
            year_offset <= year_offset + 8'd1;
          end else begin
            month <= esc_pkg::MONTH_JAN;
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (!fits || month == esc_pkg::MONTH_DEC) begin
            day   <= days[4:0] + 5'd1;
            state <= ST_DONE;
          end else begin
            days  <= diff[15:0];
            month <= month + 4'd1;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_CLK(a_done_one_cycle, done |=> !done, "done strobe longer than one cycle")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "request accepted but not busy")
  `ASSERT_CLK(a_busy_ends_done, $fell(busy) |-> $past(done), "busy dropped without done")
  `ASSERT_CLK(a_month_range, done |-> (month >= esc_pkg::MONTH_JAN && month <= esc_pkg::MONTH_DEC), "month out of range")
  `ASSERT_CLK(a_time_range, done |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60 && day != 5'd0), "time of day out of range")
  `ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !busy, "not idle after reset")

endmodule

FILE: dv/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the epoch-to-calendar converter. Requests carry a
// timestamp. Each one is converted by an in-bench calendar model and queued.
// Every done strobe is checked field by field against the oldest queued date.
// Directed corners (epoch edges, leap days, year and century edges, wrapped
// pre-2000 stamps) run first. Random stamps follow, biased toward 2000-2099
// and day boundaries, over phases with and without sender idle gaps.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

  // Seconds from 1970-01-01 to 2000-01-01 and seconds in one day
  localparam logic [31:0] SHIFT_2000   = 32'd946684800;
  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 250;
  localparam int          PHASE_ITEMS  = 600;

  typedef struct packed {
    logic [7:0] yr;
    logic [3:0] mon;
    logic [4:0] dy;
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
  } cal_t;

  // Queue of dates due from the converter, oldest first
  class calendar_scoreboard;
    cal_t        dates_due[$];
    logic [31:0] stamps_due[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Timestamp to calendar fields, leap year every fourth offset
    static function cal_t to_calendar(logic [31:0] stamp);
      logic [31:0] t;
      logic [31:0] days;
      logic [31:0] yr;
      logic [3:0]  mon;
      logic        leap;
      int unsigned mlen;
      cal_t        r;
      t    = stamp - SHIFT_2000;
      r.se = 6'(t % 60);
      t    = t / 60;
      r.mi = 6'(t % 60);
      t    = t / 60;
      r.hr = 5'(t % 24);
      days = t / 24;
      yr   = 0;
      while (days >= ((yr[1:0] == 2'd0) ? 32'd366 : 32'd365)) begin
        days = days - ((yr[1:0] == 2'd0) ? 32'd366 : 32'd365);
        yr   = yr + 1;
      end
      leap = (yr[1:0] == 2'd0);
      mon  = 4'd1;
      mlen = 31;
      while (mon < 4'd12) begin
        if (mon == 4'd2)
          mlen = leap ? 29 : 28;
        else if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11)
          mlen = 30;
        else
          mlen = 31;
        if (days < mlen)
          break;
        days = days - mlen;
        mon  = mon + 4'd1;
      end
      r.yr  = yr[7:0];
      r.mon = mon;
      r.dy  = 5'(days + 1);
      return r;
    endfunction

    function void note_request(logic [31:0] stamp);
      dates_due.push_back(to_calendar(stamp));
      stamps_due.push_back(stamp);
    endfunction

    function int pending();
      return dates_due.size();
    endfunction

    task report_mismatch(string what, logic [31:0] stamp, int got, int want);
      $display("%0t: MISMATCH %s stamp=%0d got=%0d exp=%0d", $realtime, what, stamp,
               got, want);
      errors++;
    endtask

    task check_result(cal_t got);
      cal_t        want;
      logic [31:0] stamp;
      if (dates_due.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0, 0);
        return;
      end
      want  = dates_due.pop_front();
      stamp = stamps_due.pop_front();
      if (got.yr  !== want.yr)  report_mismatch("year_offset", stamp, got.yr,  want.yr);
      if (got.mon !== want.mon) report_mismatch("month",       stamp, got.mon, want.mon);
      if (got.dy  !== want.dy)  report_mismatch("day",         stamp, got.dy,  want.dy);
      if (got.hr  !== want.hr)  report_mismatch("hour",        stamp, got.hr,  want.hr);
      if (got.mi  !== want.mi)  report_mismatch("minute",      stamp, got.mi,  want.mi);
      if (got.se  !== want.se)  report_mismatch("second",      stamp, got.se,  want.se);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] unix_seconds;
  logic        busy;
  logic        done;
  logic [7:0]  year_offset;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  calendar_scoreboard sb;
  int                 send_idle;
  int                 quiet_cycles;

  epoch_seconds_to_calendar DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .unix_seconds (unix_seconds),
    .busy         (busy),
    .done         (done),
    .year_offset  (year_offset),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Request capture, result check and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result({year_offset, month, day, hour, minute, second});
      if (start && !busy)
        sb.note_request(unix_seconds);
      if ((start && !busy) || done)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One request; optional idle gap with junk on the data port first
  task drive_request(input logic [31:0] stamp);
    int gap;
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 300);
      start        <= 1'b0;
      unix_seconds <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    unix_seconds <= stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold requests off until every pending date has come back
  task wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random stamp: full range, 2000-2099 span, day edges, near the wrap point
  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    int          pick;
    pick = $urandom_range(9);
    if (pick <= 3)
      s = $urandom;
    else if (pick <= 6)
      s = SHIFT_2000 + $urandom_range(36524) * SEC_PER_DAY + $urandom_range(86399);
    else if (pick <= 8)
      s = SHIFT_2000 + $urandom_range(49710) * SEC_PER_DAY
          + ($urandom_range(1) ? 32'd86399 : 32'd0);
    else
      case ($urandom_range(3))
        0:       s = $urandom_range(300);
        1:       s = 32'hFFFF_FFFF - $urandom_range(300);
        2:       s = SHIFT_2000 + $urandom_range(300);
        default: s = SHIFT_2000 - 1 - $urandom_range(300);
      endcase
    return s;
  endfunction

  logic [31:0] corners[$];

  initial begin
    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    unix_seconds = '0;
    send_idle    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Epoch edges, leap days, month and year ends, 2100 leap day, wrapped stamps
    corners = '{32'd0, 32'hFFFF_FFFF, 32'd946684800, 32'd946684799, 32'd946684801,
                32'd951782400, 32'd951868799, 32'd951868800, 32'd978307199,
                32'd978307200, 32'd1078099199, 32'd1234567890, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4102444799,
                32'd4102444800, 32'd4107456000, 32'd4107542399, 32'd4107542400,
                32'd4133980799, 32'd4133980800, 32'd1009843199, 32'd1009843200};
    foreach (corners[i])
      drive_request(corners[i]);
    wait_drained();

    // Random phases: no idling, heavy sender idling, light sender idling
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       send_idle = 0;
        1:       send_idle = 79;
        default: send_idle = 18;
      endcase
      repeat (PHASE_ITEMS)
        drive_request(next_stamp());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
